// ----- rtl/core/sais_pkg.sv -----
// Shared types and constants for the shifting array block.
// Used by sais_cell, sais_scan and shifting_array_insert_delete_search.
package sais_pkg;

	localparam int DATA_W    = 32;
	localparam int POS_W     = 6;
	localparam int LEN_W     = 7;
	localparam int DEPTH_DEF = 64;
	localparam int GROUP_W   = 8;
	localparam int GSEL_W    = 3;

	localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(64);
	localparam logic [DATA_W-1:0] EMPTY_WORD = '1;
	localparam logic [DATA_W-1:0] ZERO_WORD  = '0;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_SEARCH = 2'd3
	} op_t;

	// Broadcast to every cell on a transfer.
	typedef struct packed {
		logic              go;
		logic              ok;
		op_t               op;
		logic [POS_W-1:0]  pos;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] value;
	} cell_ctl_t;

	typedef struct packed {
		logic             done;
		logic             found;
		logic [POS_W-1:0] index;
	} scan_res_t;

	// Lowest set bit of an 8-bit group.
	function automatic logic [GSEL_W-1:0] first_set(input logic [GROUP_W-1:0] bits);
		logic [GSEL_W-1:0] sel;
		sel = '0;
		for (int k = GROUP_W - 1; k >= 0; k--) begin
			if (bits[k]) begin
				sel = GSEL_W'(k);
			end
		end
		return sel;
	endfunction

endpackage

// ----- rtl/core/sais_cell.sv -----
// One slot of the shifting array: holds a word, takes a neighbor's word on a shift.
// Depends on sais_pkg.
module sais_cell import sais_pkg::*; #(
	parameter int INDEX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	output logic [DATA_W-1:0] slot,
	output logic              hit
);

	logic [DATA_W-1:0] slot_q;
	logic              hit_q;
	logic              active;
	logic              at_pos;
	logic              above_pos;
	logic              below_last;
	logic              is_last;

	assign active     = INDEX < int'(ctl.len);
	assign at_pos     = INDEX == int'(ctl.pos);
	assign above_pos  = INDEX > int'(ctl.pos);
	assign below_last = (INDEX + 1) < int'(ctl.len);
	assign is_last    = (INDEX + 1) == int'(ctl.len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= EMPTY_WORD;
		end else if (ctl.go && ctl.ok) begin
			case (ctl.op)
				OP_INSERT: begin
					if (at_pos) begin
						slot_q <= ctl.value;
					end else if (above_pos && active) begin
						slot_q <= left;
					end
				end
				OP_REMOVE: begin
					if ((at_pos || above_pos) && below_last) begin
						slot_q <= right;
					end
				end
				OP_CLEAR: begin
					if (is_last) begin
						slot_q <= ZERO_WORD;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Match flag is sampled on a search transfer and held for the scan.
	always_ff @(posedge clk) begin
		if (ctl.go && ctl.op == OP_SEARCH) begin
			hit_q <= active && (slot_q == ctl.value);
		end
	end

	assign slot = slot_q;
	assign hit  = hit_q;

endmodule

// ----- rtl/core/sais_scan.sv -----
// Finds the lowest set match flag, one group of eight flags per cycle.
// Depends on sais_pkg.
module sais_scan import sais_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DEPTH-1:0] hits,
	output logic             busy,
	output scan_res_t        res
);

	localparam int NGROUP = (DEPTH + GROUP_W - 1) / GROUP_W;
	localparam int GW     = (NGROUP > 1) ? $clog2(NGROUP) : 1;
	localparam int PAD_W  = NGROUP * GROUP_W;
	localparam int IW     = GW + GSEL_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} scan_state_t;

	scan_state_t       state_q;
	logic [GW-1:0]     grp_q;
	logic [PAD_W-1:0]  hit_pad;
	logic [GROUP_W-1:0] grp_bits;
	logic              any_hit;
	logic              last_grp;
	logic [IW-1:0]     idx;
	logic [IW+POS_W-1:0] idx_wide;

	assign hit_pad  = PAD_W'(hits);
	assign grp_bits = hit_pad[int'(grp_q) * GROUP_W +: GROUP_W];
	assign any_hit  = |grp_bits;
	assign last_grp = grp_q == GW'(NGROUP - 1);
	assign idx      = {grp_q, first_set(grp_bits)};
	assign idx_wide = {{POS_W{1'b0}}, idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			grp_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					grp_q <= '0;
					if (start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (any_hit || last_grp) begin
						state_q <= ST_IDLE;
						grp_q   <= '0;
					end else begin
						grp_q <= grp_q + GW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = state_q == ST_SCAN;
	assign res.done  = busy && (any_hit || last_grp);
	assign res.found = any_hit;
	assign res.index = any_hit ? idx_wide[POS_W-1:0] : '0;

endmodule

// ----- rtl/core/shifting_array_insert_delete_search.sv -----
// Shifting array of DEPTH signed 32-bit words, all -1 after reset, of which the first
// length_in_use are active. Insert, remove and clear-last act on the transfer itself:
// every slot is a cell that loads its neighbor's word in parallel, and the result is
// ready in the output register in the cycle after the transfer. A search registers the
// match flags of every cell, then the scan unit walks 1 to ceil(DEPTH/8) groups of eight
// flags until it meets the first match or the last group. No item is taken during a scan.
// Depends on sais_pkg, sais_cell and sais_scan.
module shifting_array_insert_delete_search import sais_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [LEN_W-1:0]         cfg_wr_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               req_type,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     accepted,
	output logic                     found,
	output logic [POS_W-1:0]         found_index
);

	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  len_eff;
	logic              in_xfer;
	logic              op_ok;
	op_t               op;
	cell_ctl_t         ctl;
	logic [DATA_W-1:0] slot_w [DEPTH];
	logic [DEPTH-1:0]  hit_w;
	logic              scan_busy;
	scan_res_t         scan_res;

	logic              out_valid_q;
	logic              accepted_q;
	logic              found_q;
	logic [POS_W-1:0]  found_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (cfg_wr_en) begin
			len_q <= cfg_wr_data;
		end
	end

	assign len_eff = (int'(len_q) > DEPTH) ? LEN_W'(DEPTH) : len_q;
	assign op      = op_t'(req_type);
	assign in_stall = scan_busy || (out_valid_q && out_stall);
	assign in_xfer  = in_valid && !in_stall;

	always_comb begin
		case (op)
			OP_INSERT: op_ok = {1'b0, position} < len_eff;
			OP_REMOVE: op_ok = {1'b0, position} < len_eff;
			OP_CLEAR:  op_ok = len_eff != '0;
			default:   op_ok = 1'b1;
		endcase
	end

	assign ctl.go    = in_xfer;
	assign ctl.ok    = op_ok;
	assign ctl.op    = op;
	assign ctl.pos   = position;
	assign ctl.len   = len_eff;
	assign ctl.value = value;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = ZERO_WORD;
		end else begin : g_left
			assign left_w = slot_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = ZERO_WORD;
		end else begin : g_right
			assign right_w = slot_w[i+1];
		end

		sais_cell #(
			.INDEX(i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.left  (left_w),
			.right (right_w),
			.slot  (slot_w[i]),
			.hit   (hit_w[i])
		);
	end

	sais_scan #(
		.DEPTH(DEPTH)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.start (in_xfer && op == OP_SEARCH),
		.hits  (hit_w),
		.busy  (scan_busy),
		.res   (scan_res)
	);

	// Output register: loaded by a non-search transfer or by the end of a scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((in_xfer && op != OP_SEARCH) || scan_res.done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && op != OP_SEARCH) begin
			accepted_q    <= op_ok;
			found_q       <= 1'b0;
			found_index_q <= '0;
		end else if (scan_res.done) begin
			accepted_q    <= 1'b1;
			found_q       <= scan_res.found;
			found_index_q <= scan_res.index;
		end
	end

	assign out_valid   = out_valid_q;
	assign accepted    = accepted_q;
	assign found       = found_q;
	assign found_index = found_index_q;

endmodule

// ----- test/shifting_array_insert_delete_search_tb.sv -----
// Self-checking testbench for shifting_array_insert_delete_search: keeps a mirror of the
// slot array and the active length, predicts every result and checks it on transfer.
// Depends on sais_pkg and the shifting_array_insert_delete_search RTL.
module shifting_array_insert_delete_search_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sais_pkg::*;

	localparam int SETTLE_CYCLES  = 12;
	localparam int LONG_HOLD      = 120;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RECENT_N       = 8;

	typedef struct packed {
		logic             accepted;
		logic             found;
		logic [POS_W-1:0] slot_idx;
	} array_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_wr_en;
	logic [LEN_W-1:0]         cfg_wr_data;
	logic                     in_valid;
	logic                     in_stall;
	logic [1:0]               req_type;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     accepted;
	logic                     found;
	logic [POS_W-1:0]         found_index;

	// Mirror of the block's state
	logic [DATA_W-1:0] slot_mirror [DEPTH_DEF];
	logic [LEN_W-1:0]  mirror_len;
	logic [DATA_W-1:0] recent_values [RECENT_N];

	array_result_t pending_results[$];

	bit send_gaps = 1'b1;
	bit recv_gaps = 1'b1;
	int hold_kick = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int errors = 0;
	int n_sent = 0;
	int n_results = 0;
	int n_rejected = 0;
	int n_hits = 0;
	int n_lengths = 0;

	shifting_array_insert_delete_search #(
		.DEPTH(DEPTH_DEF)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.position   (position),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.accepted   (accepted),
		.found      (found),
		.found_index(found_index)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int active_count();
		return (int'(mirror_len) > DEPTH_DEF) ? DEPTH_DEF : int'(mirror_len);
	endfunction

	function automatic void reset_mirror();
		foreach (slot_mirror[i]) slot_mirror[i] = EMPTY_WORD;
		mirror_len = LEN_RESET;
		recent_values = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF,
			32'h8000_0000, 32'hA5A5_5A5A, 32'h2, 32'hFFFF_FFFE};
	endfunction

	// Apply one request to the mirror and return the result it produces.
	function automatic array_result_t shift_array_update(op_t op, logic [POS_W-1:0] pos,
			logic [DATA_W-1:0] val);
		array_result_t r;
		int n;
		int p;
		r = '0;
		n = active_count();
		p = int'(pos);
		case (op)
			OP_INSERT: begin
				if (p < n) begin
					for (int i = n - 1; i > p; i--) slot_mirror[i] = slot_mirror[i - 1];
					slot_mirror[p] = val;
					r.accepted = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (p < n) begin
					for (int i = p; i + 1 < n; i++) slot_mirror[i] = slot_mirror[i + 1];
					r.accepted = 1'b1;
				end
			end
			OP_CLEAR: begin
				if (n > 0) begin
					slot_mirror[n - 1] = ZERO_WORD;
					r.accepted = 1'b1;
				end
			end
			default: begin
				r.accepted = 1'b1;
				for (int i = 0; i < n; i++) begin
					if (!r.found && slot_mirror[i] == val) begin
						r.found = 1'b1;
						r.slot_idx = POS_W'(i);
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] pick_value(bit for_search);
		int n;
		int roll;
		n = active_count();
		roll = $urandom_range(0, 99);
		if (for_search && n > 0 && roll < 55) return slot_mirror[$urandom_range(0, n - 1)];
		if (roll < 75) return recent_values[$urandom_range(0, RECENT_N - 1)];
		return $urandom();
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer, with
	// valid still high so that back-to-back items need no lowering.
	task automatic send_req(op_t op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
		array_result_t r;
		while (send_gaps && $urandom_range(0, 99) < 7) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		position <= pos;
		value    <= val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = shift_array_update(op, pos, val);
		pending_results.push_back(r);
		if (op == OP_INSERT && r.accepted) recent_values[$urandom_range(0, RECENT_N - 1)] = val;
		n_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_length(logic [LEN_W-1:0] len);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= len;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		mirror_len = len;
		n_lengths++;
	endtask

	task automatic send_random(int count);
		op_t op;
		logic [POS_W-1:0] pos;
		int n;
		int roll;
		for (int k = 0; k < count; k++) begin
			n = active_count();
			roll = $urandom_range(0, 99);
			if (roll < 30) op = OP_INSERT;
			else if (roll < 55) op = OP_REMOVE;
			else if (roll < 65) op = OP_CLEAR;
			else op = OP_SEARCH;
			// Mostly in range; the rest hits every position, valid or not.
			if (n > 0 && $urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, n - 1));
			else pos = POS_W'($urandom_range(0, DEPTH_DEF - 1));
			send_req(op, pos, pick_value(op == OP_SEARCH));
		end
	endtask

	task automatic test_directed();
		// Full length from reset: all slots hold the empty marker.
		send_req(OP_SEARCH, 6'd0, 32'hFFFF_FFFF);
		send_req(OP_SEARCH, 6'd0, 32'h0);
		send_req(OP_INSERT, 6'd0, 32'h7FFF_FFFF);
		send_req(OP_INSERT, 6'd63, 32'h8000_0000);
		send_req(OP_INSERT, 6'd10, 32'h5A5A_5A5A);
		send_req(OP_SEARCH, 6'd0, 32'h8000_0000);
		send_req(OP_REMOVE, 6'd63, 32'h0);
		send_req(OP_REMOVE, 6'd0, 32'h0);
		send_req(OP_CLEAR, 6'd0, 32'h0);
		send_req(OP_SEARCH, 6'd0, 32'h0);
		send_req(OP_INSERT, 6'd1, 32'h0);
		send_req(OP_SEARCH, 6'd63, 32'h0);
		// Short array: positions at or past the length are rejected.
		set_length(7'd5);
		send_req(OP_INSERT, 6'd5, 32'h1234_5678);
		send_req(OP_REMOVE, 6'd63, 32'h0);
		send_req(OP_INSERT, 6'd4, 32'h1234_5678);
		send_req(OP_CLEAR, 6'd0, 32'hFFFF_FFFF);
		send_req(OP_SEARCH, 6'd0, 32'h5A5A_5A5A);
		send_req(OP_REMOVE, 6'd4, 32'h0);
		// No active slot: everything but search is rejected.
		set_length(7'd0);
		send_req(OP_INSERT, 6'd0, 32'h1);
		send_req(OP_REMOVE, 6'd0, 32'h0);
		send_req(OP_CLEAR, 6'd0, 32'h0);
		send_req(OP_SEARCH, 6'd0, 32'hFFFF_FFFF);
		// Length beyond the depth acts as the full depth.
		set_length(7'd127);
		send_req(OP_INSERT, 6'd63, 32'hFFFF_FFFF);
		send_req(OP_SEARCH, 6'd0, 32'h5A5A_5A5A);
		send_req(OP_CLEAR, 6'd0, 32'h0);
	endtask

	task automatic test_backpressure();
		set_length(7'd64);
		send_gaps = 1'b0;
		hold_kick++;
		// Keep offering while the receiver holds off, so the input stalls.
		send_random(50);
		send_gaps = 1'b1;
		wait_idle();
		send_random(40);
	endtask

	task automatic test_random_lengths();
		logic [LEN_W-1:0] lengths [10];
		lengths = '{7'd1, 7'd2, 7'd65, 7'd33, 7'd8, 7'd100, 7'd17, 7'd64, 7'd3, 7'd127};
		foreach (lengths[i]) begin
			set_length(lengths[i]);
			send_gaps = (i != 7);
			recv_gaps = (i != 7);
			send_random(75);
		end
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
	endtask

	// Receiver: random stalls, plus a long hold-off when kicked.
	always @(negedge clk) begin
		if (hold_kick != hold_seen) begin
			hold_seen = hold_kick;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= recv_gaps && ($urandom_range(0, 99) < 7);
		end
	end

	always @(posedge clk) begin
		array_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no request outstanding");
				errors++;
			end else begin
				want = pending_results.pop_front();
				n_results++;
				if (!accepted) n_rejected++;
				if (found) n_hits++;
				if (accepted !== want.accepted) begin
					$error("accepted: expected %0d, got %0d", want.accepted, accepted);
					errors++;
				end
				if (found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, found);
					errors++;
				end
				if (found_index !== want.slot_idx) begin
					$error("found_index: expected %0d, got %0d", want.slot_idx, found_index);
					errors++;
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("shifting_array_insert_delete_search verification failed");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		req_type    = OP_INSERT;
		position    = '0;
		value       = '0;
		reset_mirror();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_backpressure();
		test_random_lengths();
		wait_idle();

		$display("run covered %0d requests over %0d length settings", n_sent, n_lengths);
		$display("results checked: %0d, rejected: %0d, search hits: %0d",
			n_results, n_rejected, n_hits);
		if (errors == 0)
			$display("shifting_array_insert_delete_search verification clean");
		else
			$display("shifting_array_insert_delete_search verification failed");
		$finish;
	end

endmodule
